@@ rtl/afd_pkg.sv @@
// Shared types and constants for the frame deframer.
package afd_pkg;

  localparam logic [7:0]  SOF_BYTE          = 8'h7E;
  localparam logic [7:0]  SUM_BASE          = 8'hFF;
  localparam logic [15:0] MAX_LEN_RESET     = 16'd256;
  localparam int          QUEUE_DEPTH_DEF   = 4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_GOOD   = 2'd1,
    KIND_BADSUM = 2'd2,
    KIND_BADLEN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_CHECK  = 2'd1,
    OP_BADLEN = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  byte_val;
    logic [15:0] idx;
    logic [15:0] len;
  } cmd_t;

endpackage

@@ rtl/api_frame_deframer_unit.sv @@
// Top level of the delimited, length-prefixed frame deframer.
//
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid/in_stall    in_rx_byte
//   out_     output     out_valid/out_stall  kind, data, index, length, type, last
//   cfg_     input      cfg_wr_en            cfg_wr_data (max_frame_len)
//
// One byte is taken every cycle while the command queue has room; the result
// stage takes a new command whenever its output is empty or not stalled.
// A result passes through the command queue and then the registered result stage.
// Reset is synchronous and returns the parser to hunting for the start byte.
// Output stalls fill the queue of QUEUE_DEPTH entries, and then in_stall rises.
module api_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = afd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_frame_type,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import afd_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  assign in_stall = q_full;

  afd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_rx_byte  (in_rx_byte),
    .q_full      (q_full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  afd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  afd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_cmd         (head_cmd),
    .q_empty          (q_empty),
    .out_stall        (out_stall),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_frame_type   (out_frame_type),
    .out_last         (out_last)
  );

endmodule

@@ rtl/afd_front.sv @@
// Front end: frame parser that classifies received bytes into queue commands.
module afd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_rx_byte,
  input  logic          q_full,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  output logic          push,
  output afd_pkg::cmd_t push_cmd
);
  import afd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] max_len_r;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic        accept;

  assign accept    = in_valid && !q_full;
  assign count_inc = count_r + 16'd1;
  assign len_full  = {length_r[15:8], in_rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      length_r  <= '0;
      count_r   <= '0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    length_nxt        = length_r;
    count_nxt         = count_r;
    push              = 1'b0;
    push_cmd.op       = OP_DATA;
    push_cmd.byte_val = in_rx_byte;
    push_cmd.idx      = count_r;
    push_cmd.len      = length_r;
    if (accept) begin
      case (phase_r)
        PH_LEN_HI: begin
          length_nxt = {in_rx_byte, 8'h00};
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_nxt = len_full;
          count_nxt  = '0;
          if (len_full > max_len_r) begin
            phase_nxt         = PH_HUNT;
            push              = 1'b1;
            push_cmd.op       = OP_BADLEN;
            push_cmd.byte_val = '0;
            push_cmd.idx      = '0;
            push_cmd.len      = len_full;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          count_nxt   = count_inc;
          push        = 1'b1;
          push_cmd.op = OP_DATA;
          if (count_inc >= length_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_nxt    = PH_HUNT;
          push         = 1'b1;
          push_cmd.op  = OP_CHECK;
          push_cmd.idx = '0;
        end
        default: begin
          phase_nxt = (in_rx_byte == SOF_BYTE) ? PH_LEN_HI : PH_HUNT;
        end
      endcase
    end
  end

endmodule

@@ rtl/afd_queue.sv @@
// Small command queue between the parser and the result stage.
module afd_queue #(
  parameter int DEPTH = afd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  afd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output afd_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import afd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/afd_back.sv @@
// Back end: checksum accumulation and the registered result stage.
module afd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  afd_pkg::cmd_t head_cmd,
  input  logic          q_empty,
  input  logic          out_stall,
  output logic          pop,
  output logic          out_valid,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_data_byte,
  output logic [15:0]   out_byte_index,
  output logic [15:0]   out_frame_length,
  output logic [7:0]    out_frame_type,
  output logic          out_last
);
  import afd_pkg::*;

  logic        valid_r, valid_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic        last_r, last_nxt;
  logic        first;
  logic        empty_frame;
  logic [7:0]  want;

  assign pop         = !q_empty && (!valid_r || !out_stall);
  assign first       = (head_cmd.idx == 16'd0);
  assign empty_frame = (head_cmd.len == 16'd0);
  assign want        = empty_frame ? SUM_BASE : SUM_BASE - sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sum_r   <= '0;
      type_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    data_r  <= data_nxt;
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    ftype_r <= ftype_nxt;
    last_r  <= last_nxt;
  end

  always_comb begin
    valid_nxt = valid_r && out_stall;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ftype_nxt = ftype_r;
    last_nxt  = last_r;
    if (pop) begin
      valid_nxt = 1'b1;
      len_nxt   = head_cmd.len;
      case (head_cmd.op)
        OP_DATA: begin
          sum_nxt   = (first ? 8'h00 : sum_r) + head_cmd.byte_val;
          type_nxt  = first ? head_cmd.byte_val : type_r;
          kind_nxt  = KIND_DATA;
          data_nxt  = head_cmd.byte_val;
          idx_nxt   = head_cmd.idx;
          ftype_nxt = '0;
          last_nxt  = 1'b0;
        end
        OP_CHECK: begin
          kind_nxt  = (head_cmd.byte_val == want) ? KIND_GOOD : KIND_BADSUM;
          data_nxt  = head_cmd.byte_val;
          idx_nxt   = '0;
          ftype_nxt = empty_frame ? 8'h00 : type_r;
          last_nxt  = 1'b1;
        end
        default: begin
          kind_nxt  = KIND_BADLEN;
          data_nxt  = '0;
          idx_nxt   = '0;
          ftype_nxt = '0;
          last_nxt  = 1'b1;
        end
      endcase
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = data_r;
  assign out_byte_index   = idx_r;
  assign out_frame_length = len_r;
  assign out_frame_type   = ftype_r;
  assign out_last         = last_r;

endmodule

@@ rtl/afd_checker.sv @@
// Port-level checker for the frame deframer and its bind statement.
module afd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_byte_index,
  input logic [7:0]  out_frame_type,
  input logic        out_last
);
  import afd_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_data_byte))
    else $error("stalled transaction changed");

  a_last_marks_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != KIND_DATA)))
    else $error("last flag disagrees with result kind");

  a_data_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_frame_type == 8'h00)
    else $error("frame type set on payload byte");

  a_badlen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BADLEN |->
      out_data_byte == 8'h00 && out_byte_index == 16'h0000 && out_frame_type == 8'h00)
    else $error("length error carries nonzero fields");

endmodule

bind api_frame_deframer_unit afd_checker u_afd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_data_byte  (out_data_byte),
  .out_byte_index (out_byte_index),
  .out_frame_type (out_frame_type),
  .out_last       (out_last)
);
